@@ design/srsw_pkg.sv @@
// shared types and constants for the selective-repeat sender window
// no dependencies; imported by every module of the block
`default_nettype none

package srsw_pkg;

  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_BITS     = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_BITS = 64;
  localparam int WSIZE_BITS   = 3;
  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(4);

  // stream packing
  localparam int IN_DATA_BITS  = PAYLOAD_BITS + SEQ_BITS + 1;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_DATA_BITS = PAYLOAD_BITS + 3 * SEQ_BITS + 6;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;

  typedef enum logic [1:0] {
    FN_SEND    = 2'd0,
    FN_ACK     = 2'd1,
    FN_TIMEOUT = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } st_t;

  typedef struct packed {
    logic accepted;
    logic tx_valid;
    seq_t tx_seq;
    logic timer_start;
    logic timer_stop;
    seq_t timer_seq;
    logic ack_taken;
    seq_t window_base;
    logic window_full;
    logic from_store;
  } win_res_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    seq_t addr;
  } mem_cmd_t;

endpackage

`default_nettype wire

@@ design/selective_repeat_sender_window.sv @@
// Selective-repeat ARQ sender window, top level.
// Channels: in_* carries one item per transfer; in_tuser holds the item kind
// (0 send, 1 ack, 2 timer expiry) and in_tdata the payload, number and
// checksum flag. out_* carries exactly one result per item. cfg_* writes the
// window size (1..7, reset value 4) and is always ready; write it only while
// the block is idle.
// Timing: an item is taken in the idle state; the window result and the packet
// store read (for a timer expiry) are registered, then loaded into the output
// register in the response state, and a new item can be taken in the cycle that
// out_tvalid rises. A new item is not taken until the last one's result has
// been loaded into the output register.
// Stall: a result waits in the output register while out_tready is low; one
// more item may be taken meanwhile, and its result holds until the register
// frees, with in_tready low until then.
// Reset (rst_n low, synchronous): next and base numbers 0, window not full,
// all acked bits clear, window size 4, no result pending. Stored payloads are
// not cleared; no clearing pass is needed.
// Depends on srsw_pkg, srsw_window and srsw_pkt_mem.
`default_nettype none

module selective_repeat_sender_window
  import srsw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [WSIZE_BITS-1:0]  cfg_data,     // window_size
  // input items
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,     // payload, seq_number, checksum_ok
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,     // func
  // results
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // accepted, tx_valid, tx_seq, tx_payload, timer_start, timer_stop, timer_seq,
  // ack_taken, window_base, window_full
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  st_t                    state_r, state_nxt;
  logic                   fire, load;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  payload_t               payload_r, rdata, tx_payload;
  mem_cmd_t               mem_cmd;
  win_res_t               res;

  assign cfg_ready = 1'b1;
  assign fire      = in_tvalid & in_tready;

  srsw_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_wsize   (cfg_data),
    .fire        (fire),
    .func        (in_tuser),
    .seq         (in_tdata[PAYLOAD_BITS +: SEQ_BITS]),
    .checksum_ok (in_tdata[PAYLOAD_BITS + SEQ_BITS]),
    .mem_cmd     (mem_cmd),
    .res         (res)
  );

  srsw_pkt_mem u_pkt_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .wdata (in_tdata[PAYLOAD_BITS-1:0]),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (fire) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    load      = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_RESP: load = !out_valid_r || out_tready;
      default: begin
      end
    endcase
  end

  assign tx_payload = res.from_store ? rdata : (res.tx_valid ? payload_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      payload_r <= in_tdata[PAYLOAD_BITS-1:0];
    end
    if (load) begin
      out_data_r <= OUT_TDATA_W'({res.window_full, res.window_base, res.ack_taken,
                                  res.timer_seq, res.timer_stop, res.timer_start,
                                  tx_payload, res.tx_seq, res.tx_valid, res.accepted});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ design/srsw_pkt_mem.sv @@
// packet store: one payload word per sequence slot, registered read
// depends on srsw_pkg
`default_nettype none

module srsw_pkt_mem
  import srsw_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_cmd_t cmd,
  input  wire payload_t wdata,
  output payload_t      rdata
);

  payload_t mem [SEQ_SPACE];
  payload_t rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/srsw_window.sv @@
// window state: next/base numbers, full flag, acked bits and the base slide
// depends on srsw_pkg; drives the packet store command
`default_nettype none

module srsw_window
  import srsw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [WSIZE_BITS-1:0] cfg_wsize,
  input  wire logic                  fire,
  input  wire logic [1:0]            func,
  input  wire seq_t                  seq,
  input  wire logic                  checksum_ok,
  output mem_cmd_t                   mem_cmd,
  output win_res_t                   res
);

  logic [WSIZE_BITS-1:0] wsize_r;
  seq_t                  next_r, next_nxt;
  seq_t                  base_r, base_nxt;
  logic                  full_r, full_nxt;
  logic [SEQ_SPACE-1:0]  acked_r, acked_nxt;
  win_res_t              res_r, res_nxt;

  seq_t                  off, cnt, idx, next_inc;
  logic [SEQ_SPACE-1:0]  acked_set;
  logic                  run;
  logic [SEQ_BITS:0]     nslide;

  assign next_inc = next_r + seq_t'(1);
  assign off      = seq - base_r;
  assign cnt      = next_r - base_r;

  always_comb begin
    next_nxt  = next_r;
    base_nxt  = base_r;
    full_nxt  = full_r;
    acked_nxt = acked_r;
    res_nxt   = '0;
    mem_cmd   = '{wr_en: 1'b0, rd_en: fire, addr: next_r};
    acked_set = acked_r;
    run       = 1'b1;
    nslide    = '0;
    idx       = base_r;
    case (func_t'(func))
      FN_SEND: begin
        if (!full_r) begin
          mem_cmd.wr_en       = fire;
          res_nxt.accepted    = 1'b1;
          res_nxt.tx_valid    = 1'b1;
          res_nxt.tx_seq      = next_r;
          res_nxt.timer_start = 1'b1;
          res_nxt.timer_seq   = next_r;
          next_nxt            = next_inc;
          if (seq_t'(base_r + seq_t'(wsize_r)) == next_inc) begin
            full_nxt = 1'b1;
          end
        end
      end
      FN_ACK: begin
        if (checksum_ok && (off < cnt)) begin
          res_nxt.ack_taken  = 1'b1;
          res_nxt.timer_stop = 1'b1;
          res_nxt.timer_seq  = seq;
          acked_set[seq]     = 1'b1;
          acked_nxt          = acked_set;
          // slide base over the run of acked slots
          for (int i = 0; i < SEQ_SPACE; i++) begin
            idx = base_r + seq_t'(i);
            run = run & acked_set[idx];
            if (run) begin
              acked_nxt[idx] = 1'b0;
              nslide         = nslide + (SEQ_BITS+1)'(1);
            end
          end
          base_nxt = base_r + nslide[SEQ_BITS-1:0];
          if (nslide != '0) begin
            full_nxt = 1'b0;
          end
        end
      end
      FN_TIMEOUT: begin
        mem_cmd.addr        = seq;
        res_nxt.tx_valid    = 1'b1;
        res_nxt.tx_seq      = seq;
        res_nxt.timer_start = 1'b1;
        res_nxt.timer_seq   = seq;
        res_nxt.from_store  = 1'b1;
      end
      default: begin
      end
    endcase
    res_nxt.window_base = base_nxt;
    res_nxt.window_full = full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WSIZE_RESET;
      next_r  <= '0;
      base_r  <= '0;
      full_r  <= 1'b0;
      acked_r <= '0;
    end else begin
      if (cfg_we) begin
        wsize_r <= cfg_wsize;
      end
      if (fire) begin
        next_r  <= next_nxt;
        base_r  <= base_nxt;
        full_r  <= full_nxt;
        acked_r <= acked_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for selective_repeat_sender_window: directed and random send, ack and
// timer expiry traffic, checked against an in-bench model of the sliding window
// depends on srsw_pkg and the block's top level only
`timescale 1ns / 100ps

module tb;
  import srsw_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 45;
  localparam int TAIL_ITEMS = 100;

  // packed so that the bit layout matches out_tdata from bit 0 up
  typedef struct packed {
    logic     window_full;
    seq_t     window_base;
    logic     ack_taken;
    seq_t     timer_seq;
    logic     timer_stop;
    logic     timer_start;
    payload_t tx_payload;
    seq_t     tx_seq;
    logic     tx_valid;
    logic     accepted;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [WSIZE_BITS-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [IN_TUSER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // window model state
  seq_t                  win_next;
  seq_t                  win_base;
  logic                  win_full;
  logic [WSIZE_BITS-1:0] win_size;
  logic [SEQ_SPACE-1:0]  acked_slot;
  logic [SEQ_SPACE-1:0]  slot_written;
  payload_t              payload_store [SEQ_SPACE];

  result_t pending_results [$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_cycles = 0;
  logic item_had_effect;

  int n_items, n_sent, n_refused, n_acks, n_resent;
  int n_checked, mismatches;

  selective_repeat_sender_window u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t window_predict(input logic [1:0] fn, input payload_t pl,
                                             input seq_t sq, input logic ck);
    result_t r;
    seq_t    off;
    seq_t    cnt;
    r = '0;
    case (fn)
      FN_SEND: begin
        if (!win_full) begin
          payload_store[win_next] = pl;
          slot_written[win_next] = 1'b1;
          r.accepted = 1'b1;
          r.tx_valid = 1'b1;
          r.tx_seq = win_next;
          r.tx_payload = pl;
          r.timer_start = 1'b1;
          r.timer_seq = win_next;
          win_next = win_next + 1'b1;
          if (seq_t'(win_base + win_size) == win_next) win_full = 1'b1;
        end
      end
      FN_ACK: begin
        off = sq - win_base;
        cnt = win_next - win_base;
        if (ck && off < cnt) begin
          r.ack_taken = 1'b1;
          r.timer_stop = 1'b1;
          r.timer_seq = sq;
          acked_slot[sq] = 1'b1;
          for (int n = 0; n < SEQ_SPACE && acked_slot[win_base]; n++) begin
            acked_slot[win_base] = 1'b0;
            win_base = win_base + 1'b1;
            win_full = 1'b0;
          end
        end
      end
      FN_TIMEOUT: begin
        r.tx_valid = 1'b1;
        r.tx_seq = sq;
        r.tx_payload = payload_store[sq];
        r.timer_start = 1'b1;
        r.timer_seq = sq;
      end
      default: ;
    endcase
    r.window_base = win_base;
    r.window_full = win_full;
    return r;
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf({"acc=%0b tx=%0b seq=%0d pay=%h start=%0b stop=%0b",
                      " tseq=%0d ack=%0b base=%0d full=%0b"},
                     r.accepted, r.tx_valid, r.tx_seq, r.tx_payload, r.timer_start,
                     r.timer_stop, r.timer_seq, r.ack_taken, r.window_base, r.window_full);
  endfunction

  function automatic payload_t rand_payload();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one item transfer, then the model step
  task automatic push_item(input logic [1:0] fn, input payload_t pl, input seq_t sq,
                           input logic ck);
    result_t r;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({ck, sq, pl});
    in_tuser <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = window_predict(fn, pl, sq, ck);
    pending_results.push_back(r);
    item_had_effect = r.accepted | r.ack_taken | r.tx_valid;
    n_items++;
    if (fn == FN_SEND) begin
      if (r.accepted) n_sent++;
      else n_refused++;
    end
    if (r.ack_taken) n_acks++;
    if (fn == FN_TIMEOUT && r.tx_valid) n_resent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [WSIZE_BITS-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_size = w;
  endtask

  // ack the base until nothing is outstanding
  task automatic settle_window();
    while (win_next != win_base) push_item(FN_ACK, rand_payload(), win_base, 1'b1);
  endtask

  task automatic random_item();
    int   pick;
    seq_t outstanding;
    seq_t sq;
    pick = $urandom_range(0, 99);
    outstanding = win_next - win_base;
    sq = seq_t'($urandom);
    if (pick < 45 || (outstanding == 0 && pick < 85)) begin
      push_item(FN_SEND, rand_payload(), sq, 1'($urandom));
    end else if (pick < 72) begin
      if ($urandom_range(0, 2) != 0) sq = win_base + seq_t'($urandom_range(0, outstanding - 1));
      else sq = win_base;
      push_item(FN_ACK, rand_payload(), sq, 1'b1);
    end else if (pick < 85) begin
      sq = win_base + seq_t'($urandom_range(0, outstanding - 1));
      push_item(FN_TIMEOUT, rand_payload(), sq, 1'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: push_item(FN_ACK, rand_payload(), sq, 1'($urandom));
        1: push_item(FN_UNUSED, rand_payload(), sq, 1'($urandom));
        2: begin
          if (slot_written != '0) begin
            while (!slot_written[sq]) sq = seq_t'($urandom);
            push_item(FN_TIMEOUT, rand_payload(), sq, 1'($urandom));
          end else begin
            push_item(FN_SEND, rand_payload(), sq, 1'($urandom));
          end
        end
        default: push_item(FN_SEND, rand_payload(), sq, 1'($urandom));
      endcase
    end
  endtask

  task automatic run_random(input int count);
    int effect_count;
    effect_count = 0;
    while (effect_count < count) begin
      random_item();
      if (item_had_effect) effect_count++;
    end
  endtask

  task automatic test_reset_state();
    push_item(FN_ACK, '0, 3'd0, 1'b1);                      // empty window
    push_item(FN_UNUSED, '1, 3'd7, 1'b1);
    push_item(FN_SEND, '0, 3'd7, 1'b0);
    push_item(FN_SEND, '1, 3'd0, 1'b1);
    push_item(FN_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 3'd5, 1'b0);
    push_item(FN_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 3'd2, 1'b1); // fills the default window
    push_item(FN_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0); // refused
    push_item(FN_TIMEOUT, '0, 3'd0, 1'b0);
    push_item(FN_TIMEOUT, '1, 3'd3, 1'b1);
    push_item(FN_ACK, '1, 3'd1, 1'b0);                      // bad checksum
    push_item(FN_ACK, '0, 3'd5, 1'b1);                      // past next number
    push_item(FN_ACK, '0, 3'd1, 1'b1);                      // out of order
    push_item(FN_ACK, '1, 3'd1, 1'b1);                      // repeated ack
    push_item(FN_ACK, '0, 3'd0, 1'b1);                      // base slides over two
    push_item(FN_ACK, '0, 3'd3, 1'b1);
    push_item(FN_ACK, '0, 3'd2, 1'b1);
  endtask

  task automatic test_min_window();
    write_window(WSIZE_BITS'(1));
    push_item(FN_SEND, 64'hFFFF_0000_FFFF_0000, 3'd6, 1'b0);
    push_item(FN_SEND, 64'h0000_FFFF_0000_FFFF, 3'd1, 1'b1);
    push_item(FN_TIMEOUT, '0, win_base, 1'b0);
    push_item(FN_ACK, '0, win_base, 1'b1);
  endtask

  task automatic test_window_sizes();
    int sizes [8];
    sizes = '{1, 7, 3, 5, 2, 6, 4, 7};
    for (int p = 0; p < 8; p++) begin
      write_window(WSIZE_BITS'(sizes[p]));
      tx_idle_on = (p % 3 != 1);
      rx_idle_on = (p % 3 != 2);
      run_random(PHASE_ITEMS);
      settle_window();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver stops long enough that the block backs up into its input
  task automatic test_receiver_hold();
    write_window(WSIZE_BITS'(7));
    tx_idle_on = 1'b0;
    hold_cycles = 60;
    repeat (16) random_item();
    tx_idle_on = 1'b1;
    settle_window();
  endtask

  task automatic test_no_idle();
    write_window(WSIZE_BITS'($urandom_range(1, 7)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(TAIL_ITEMS);
    settle_window();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    win_next = '0;
    win_base = '0;
    win_full = 1'b0;
    win_size = WSIZE_RESET;
    acked_slot = '0;
    slot_written = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_min_window();
    test_window_sizes();
    test_receiver_hold();
    test_no_idle();
    drain();
    $display("%0d items over window sizes 1 to 7: %0d sends taken, %0d refused,",
             n_items, n_sent, n_refused);
    $display("%0d acks taken, %0d retransmits, %0d results checked, %0d mismatches",
             n_acks, n_resent, n_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side ready, with random stalls and the long hold
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %s", show_result(got));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d: expected %s", n_checked, show_result(want));
            $display("                        actual %s", show_result(got));
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
